### rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

	localparam int MAX_PAGES = 1024;
	localparam int WORD_BITS = 32;
	localparam int MAP_WORDS = MAX_PAGES / WORD_BITS;
	localparam int PAGE_W = $clog2(MAX_PAGES);
	localparam int COUNT_W = PAGE_W + 1;
	localparam int WIDX_W = $clog2(MAP_WORDS);
	localparam int BIDX_W = $clog2(WORD_BITS);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = COUNT_W;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [WIDX_W-1:0] widx_t;
	typedef logic [BIDX_W-1:0] bidx_t;

	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_ALLOC = 2'd1,
		MODE_FREE  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_PAGE   = 2'd1,
		ST_BAD_PAGE  = 2'd2,
		ST_RESERVED  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_FREE = 1'd0,
		REG_PAGE_LIMIT = 1'd1
	} reg_idx_t;

	localparam count_t PAGE_LIMIT_RST = count_t'(MAX_PAGES);

endpackage

`default_nettype wire

### rtl/bpa_in_if.sv
`default_nettype none

interface bpa_in_if;
	logic             valid;
	logic             ready;
	bpa_pkg::mode_t   mode;
	bpa_pkg::page_t   page_number;

	modport source (output valid, output mode, output page_number, input ready);
	modport sink (input valid, input mode, input page_number, output ready);
endinterface

`default_nettype wire

### rtl/bpa_out_if.sv
`default_nettype none

interface bpa_out_if;
	logic               valid;
	logic               ready;
	bpa_pkg::page_t     granted_page;
	bpa_pkg::status_t   status;
	bpa_pkg::count_t    free_count;

	modport source (output valid, output granted_page, output status, output free_count,
		input ready);
	modport sink (input valid, input granted_page, input status, input free_count,
		output ready);
endinterface

`default_nettype wire

### rtl/bpa_lowbit.sv
`default_nettype none

// Lowest set bit of a map word: its index, and the word with that bit cleared.
module bpa_lowbit (
	input  wire bpa_pkg::word_t word,
	output logic                found,
	output bpa_pkg::bidx_t      bit_idx,
	output bpa_pkg::word_t      cleared
);

	assign found   = (word != '0);
	assign cleared = word & (word - bpa_pkg::word_t'(1));

	// scan downward so the lowest set bit wins
	always_comb begin
		bit_idx = '0;
		for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (word[i]) begin
				bit_idx = bpa_pkg::bidx_t'(i);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/bitmap_page_allocator.sv
// Free-page bitmap allocator, one item at a time, map held in a 32x32 synchronous RAM.
// Init: one RAM word written per cycle, every map word in turn, then the result.
// Allocate: one map word examined per cycle from the search pointer; no scan if count 0.
// Free: read, modify, write back. Rejected free and unused mode go straight to the result.
// Next item accepted once the result is in the output register (after the prior one is taken).
// Reset (arst_n low): all pages in use via per-word valid bits, count and pointer zero.
`default_nettype none

module bitmap_page_allocator (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire [bpa_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [bpa_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	bpa_in_if.sink                                in_ch,
	bpa_out_if.source                             out_ch
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INIT = 5'b00010,
		S_SCAN = 5'b00100,
		S_FREE = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                state_q;
	bpa_pkg::page_t        first_free_q;
	bpa_pkg::count_t       page_limit_q;
	bpa_pkg::count_t       count_q;
	bpa_pkg::widx_t        search_q;
	bpa_pkg::widx_t        idx_q;
	bpa_pkg::widx_t        tried_q;
	bpa_pkg::page_t        page_q;
	bpa_pkg::page_t        res_page_q;
	bpa_pkg::status_t      res_status_q;
	logic                  out_valid_q;
	bpa_pkg::page_t        out_page_q;
	bpa_pkg::status_t      out_status_q;
	bpa_pkg::count_t       out_count_q;

	// map storage, valid bits stand in for the all-zero reset
	bpa_pkg::word_t        mem [bpa_pkg::MAP_WORDS];
	logic [bpa_pkg::MAP_WORDS-1:0] valid_q;
	bpa_pkg::word_t        rdata_q;
	logic                  rvalid_q;

	bpa_pkg::widx_t        rd_addr;
	logic                  we;
	bpa_pkg::widx_t        wr_addr;
	bpa_pkg::word_t        wr_data;

	bpa_pkg::count_t       eff_limit;
	bpa_pkg::count_t       first_ext;
	bpa_pkg::count_t       base;
	bpa_pkg::count_t       base_end;
	bpa_pkg::word_t        ge_mask;
	bpa_pkg::word_t        lt_mask;
	bpa_pkg::word_t        word_eff;
	logic                  hit;
	bpa_pkg::bidx_t        hit_bit;
	bpa_pkg::word_t        hit_cleared;
	logic                  in_acc;
	bpa_pkg::word_t        free_bit;

	assign in_acc    = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign eff_limit = (page_limit_q > bpa_pkg::PAGE_LIMIT_RST) ? bpa_pkg::PAGE_LIMIT_RST
		: page_limit_q;
	assign first_ext = bpa_pkg::count_t'(first_free_q);
	assign word_eff  = rvalid_q ? rdata_q : '0;
	assign free_bit  = bpa_pkg::word_t'(1) << page_q[bpa_pkg::BIDX_W-1:0];

	// init mask for word idx_q: bits in [first_free, eff_limit)
	assign base     = bpa_pkg::count_t'({idx_q, {bpa_pkg::BIDX_W{1'b0}}});
	assign base_end = base + bpa_pkg::count_t'(bpa_pkg::WORD_BITS);

	always_comb begin
		priority if (first_ext <= base) begin
			ge_mask = '1;
		end else if (first_ext >= base_end) begin
			ge_mask = '0;
		end else begin
			ge_mask = '1 << first_ext[bpa_pkg::BIDX_W-1:0];
		end
		priority if (eff_limit >= base_end) begin
			lt_mask = '1;
		end else if (eff_limit <= base) begin
			lt_mask = '0;
		end else begin
			lt_mask = ~('1 << eff_limit[bpa_pkg::BIDX_W-1:0]);
		end
	end

	bpa_lowbit u_lowbit (
		.word    (word_eff),
		.found   (hit),
		.bit_idx (hit_bit),
		.cleared (hit_cleared)
	);

	// read address: first word at accept, then the next word each scan cycle
	always_comb begin
		priority if (state_q == S_SCAN) begin
			rd_addr = idx_q + bpa_pkg::widx_t'(1);
		end else if (in_ch.mode == bpa_pkg::MODE_ALLOC) begin
			rd_addr = search_q;
		end else begin
			rd_addr = in_ch.page_number[bpa_pkg::PAGE_W-1 -: bpa_pkg::WIDX_W];
		end
	end

	// write port
	always_comb begin
		we      = 1'b0;
		wr_addr = idx_q;
		wr_data = ge_mask & lt_mask;
		unique case (state_q)
			S_INIT: begin
				we = 1'b1;
			end
			S_SCAN: begin
				we      = hit;
				wr_data = hit_cleared;
			end
			S_FREE: begin
				we      = 1'b1;
				wr_addr = page_q[bpa_pkg::PAGE_W-1 -: bpa_pkg::WIDX_W];
				wr_data = word_eff | free_bit;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[rd_addr];
			if (we) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_free_q <= '0;
			page_limit_q <= bpa_pkg::PAGE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (bpa_pkg::reg_idx_t'(cfg_index))
				bpa_pkg::REG_FIRST_FREE:
					first_free_q <= cfg_wdata[bpa_pkg::PAGE_W-1:0];
				bpa_pkg::REG_PAGE_LIMIT:
					page_limit_q <= cfg_wdata[bpa_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			search_q     <= '0;
			idx_q        <= '0;
			tried_q      <= '0;
			page_q       <= '0;
			res_page_q   <= '0;
			res_status_q <= bpa_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						page_q       <= in_ch.page_number;
						res_page_q   <= '0;
						res_status_q <= bpa_pkg::ST_OK;
						unique case (in_ch.mode)
							bpa_pkg::MODE_INIT: begin
								idx_q   <= '0;
								count_q <= (eff_limit > first_ext) ? eff_limit - first_ext : '0;
								state_q <= S_INIT;
							end
							bpa_pkg::MODE_ALLOC: begin
								idx_q   <= search_q;
								tried_q <= '0;
								if (count_q == '0) begin
									res_status_q <= bpa_pkg::ST_NO_PAGE;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							bpa_pkg::MODE_FREE: begin
								if (bpa_pkg::count_t'(in_ch.page_number) >= eff_limit) begin
									res_status_q <= bpa_pkg::ST_BAD_PAGE;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_FREE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INIT: begin
					idx_q <= idx_q + bpa_pkg::widx_t'(1);
					if (idx_q == bpa_pkg::widx_t'(bpa_pkg::MAP_WORDS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					priority if (hit) begin
						search_q   <= idx_q;
						res_page_q <= {idx_q, hit_bit};
						count_q    <= count_q - bpa_pkg::count_t'(1);
						state_q    <= S_DONE;
					end else if (tried_q == bpa_pkg::widx_t'(bpa_pkg::MAP_WORDS - 1)) begin
						res_status_q <= bpa_pkg::ST_NO_PAGE;
						state_q      <= S_DONE;
					end else begin
						idx_q   <= idx_q + bpa_pkg::widx_t'(1);
						tried_q <= tried_q + bpa_pkg::widx_t'(1);
					end
				end
				S_FREE: begin
					if (count_q < bpa_pkg::PAGE_LIMIT_RST) begin
						count_q <= count_q + bpa_pkg::count_t'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
			out_page_q   <= res_page_q;
			out_status_q <= res_status_q;
			out_count_q  <= count_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.granted_page = out_page_q;
	assign out_ch.status       = out_status_q;
	assign out_ch.free_count   = out_count_q;

endmodule

`default_nettype wire
